// File: src/gqtl_pkg.sv
// Shared types, codes and helpers of the glyph quad text layout block.
package gqtl_pkg;

  typedef enum logic [2:0] {
    OP_GLYPH  = 3'd0,
    OP_KERN   = 3'd1,
    OP_CURSOR = 3'd2,
    OP_CHAR   = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  localparam logic [1:0] WSEL_CODE = 2'd0;
  localparam logic [1:0] WSEL_BOX  = 2'd1;
  localparam logic [1:0] WSEL_UV   = 2'd2;
  localparam logic [1:0] WSEL_ADV  = 2'd3;
  localparam logic [1:0] WSEL_X    = 2'd0;
  localparam logic [1:0] WSEL_Y    = 2'd1;

  localparam logic [1:0] CFG_GLYPH_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHAR_SIZE   = 2'd1;
  localparam logic [1:0] CFG_KERN_RATIO  = 2'd2;
  localparam logic [1:0] CFG_TEXT_COLOR  = 2'd3;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRD, ST_SCMP, ST_CALC1, ST_CALC2,
    ST_KRD, ST_KCMP, ST_ADV1, ST_ADV2, ST_ADV3, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  table_index;
    logic [1:0]  word_select;
    logic [63:0] load_value;
    logic [31:0] code;
    logic [31:0] next_code;
    logic        has_next;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        bound_u_min;
    logic [15:0]        bound_v_min;
    logic [15:0]        bound_u_max;
    logic [15:0]        bound_v_max;
    logic [31:0]        vertex_color;
    logic               last_corner;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > $signed(36'h0_7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (v < $signed(36'hF_8000_0000)) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: src/gqtl_if.sv
// Valid/ready channel interfaces for the layout block's input and result items.
interface gqtl_in_if import gqtl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gqtl_out_if import gqtl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/gqtl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gqtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/glyph_quad_text_layout.sv
// Text layout: glyph binary search, kerning scan, quad corner output.
// Load, cursor and clear items finish as they are accepted. A character runs a binary
// glyph search (a glyph RAM read and compare per probe); when found with vertex room,
// corner calculation, a kerning RAM scan, the advance and 4 corner transfers follow.
// One item at a time; the input is ready only when the previous item is finished.
// Synchronous active-low reset clears cursor, vertex count and control; config gets defaults.
module glyph_quad_text_layout
  import gqtl_pkg::*;
#(
  parameter int GLYPH_ENTRIES   = 128,
  parameter int KERNING_ENTRIES = 1024,
  parameter int VERTEX_CAPACITY = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  gqtl_in_if.sink     in_ch,
  gqtl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int GW  = $clog2(GLYPH_ENTRIES);
  localparam int KW  = $clog2(KERNING_ENTRIES);
  localparam int SW  = GW + 2;
  localparam int KIW = (KW + 1 > 11) ? KW + 1 : 11;
  localparam int VCW = $clog2(VERTEX_CAPACITY) + 1;

  state_t state_r, state_nxt;
  logic [7:0]  glyph_count_r;
  logic [15:0] char_size_r, kern_ratio_r;
  logic [31:0] text_color_r;
  logic signed [31:0] curx_r, curx_nxt, cury_r, cury_nxt;
  logic [VCW-1:0] vcount_r, vcount_nxt;
  logic signed [SW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid;
  logic [31:0] code_r, code_nxt, next_r, next_nxt;
  logic has_next_r, has_next_nxt;
  logic [63:0] box_r, box_nxt, uv_r, uv_nxt;
  logic [35:0] adv_r, adv_nxt;
  logic signed [31:0] left_r, left_nxt, top_r, top_nxt, right_r, right_nxt;
  logic signed [31:0] bottom_r, bottom_nxt;
  logic [KIW-1:0] kidx_r, kidx_nxt, khi_r, khi_nxt, kinc;
  logic signed [15:0] kern_r, kern_nxt;
  logic signed [33:0] m1_r, m1_nxt;
  logic signed [50:0] m2_r, m2_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic out_valid_r, out_valid_nxt;

  logic in_fire, out_fire;
  in_item_t it;
  logic glyph_idx_ok, kern_idx_ok;
  logic [31:0] g_code_rd, k_code_rd;
  logic [63:0] g_box_rd, g_uv_rd;
  logic [35:0] g_adv_rd;
  logic [15:0] k_amt_rd;
  logic [31:0] glyph_n;
  logic signed [SW-1:0] hi_step, lo_step;
  logic signed [32:0] px, py;
  logic [31:0] pw, ph;
  logic signed [35:0] sx, sy, sr, sb, sadv;
  logic signed [16:0] ksum;
  logic [KIW-1:0] khi_field, kent;

  assign it       = in_ch.payload;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign glyph_idx_ok = (32'(it.table_index) < 32'(GLYPH_ENTRIES));
  assign kern_idx_ok  = (32'(it.table_index) < 32'(KERNING_ENTRIES));

  assign mid = (lo_r + hi_r) >>> 1;

  gqtl_ram #(.WIDTH(32), .DEPTH(GLYPH_ENTRIES)) u_gcode (
    .clk, .we(in_fire && it.opcode == OP_GLYPH && glyph_idx_ok && it.word_select == WSEL_CODE),
    .waddr(GW'(it.table_index)), .wdata(it.load_value[31:0]),
    .raddr(mid[GW-1:0]), .rdata(g_code_rd));
  gqtl_ram #(.WIDTH(64), .DEPTH(GLYPH_ENTRIES)) u_gbox (
    .clk, .we(in_fire && it.opcode == OP_GLYPH && glyph_idx_ok && it.word_select == WSEL_BOX),
    .waddr(GW'(it.table_index)), .wdata(it.load_value),
    .raddr(mid[GW-1:0]), .rdata(g_box_rd));
  gqtl_ram #(.WIDTH(64), .DEPTH(GLYPH_ENTRIES)) u_guv (
    .clk, .we(in_fire && it.opcode == OP_GLYPH && glyph_idx_ok && it.word_select == WSEL_UV),
    .waddr(GW'(it.table_index)), .wdata(it.load_value),
    .raddr(mid[GW-1:0]), .rdata(g_uv_rd));
  gqtl_ram #(.WIDTH(36), .DEPTH(GLYPH_ENTRIES)) u_gadv (
    .clk, .we(in_fire && it.opcode == OP_GLYPH && glyph_idx_ok && it.word_select == WSEL_ADV),
    .waddr(GW'(it.table_index)), .wdata(it.load_value[35:0]),
    .raddr(mid[GW-1:0]), .rdata(g_adv_rd));
  gqtl_ram #(.WIDTH(48), .DEPTH(KERNING_ENTRIES)) u_kern (
    .clk, .we(in_fire && it.opcode == OP_KERN && kern_idx_ok),
    .waddr(KW'(it.table_index)), .wdata(it.load_value[47:0]),
    .raddr(kidx_r[KW-1:0]), .rdata({k_amt_rd, k_code_rd}));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_count_r <= 8'd0;
      char_size_r   <= 16'd12288;
      kern_ratio_r  <= 16'd4096;
      text_color_r  <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLYPH_COUNT: glyph_count_r <= cfg_wdata[7:0];
        CFG_CHAR_SIZE:   char_size_r   <= cfg_wdata[15:0];
        CFG_KERN_RATIO:  kern_ratio_r  <= cfg_wdata[15:0];
        CFG_TEXT_COLOR:  text_color_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Datapath terms.
  always_comb begin
    glyph_n   = (32'(glyph_count_r) > 32'(GLYPH_ENTRIES)) ? 32'(GLYPH_ENTRIES)
                                                          : 32'(glyph_count_r);
    hi_step   = mid - SW'(1);
    lo_step   = mid + SW'(1);
    px        = $signed(box_r[15:0]) * $signed({1'b0, char_size_r});
    py        = $signed(box_r[31:16]) * $signed({1'b0, char_size_r});
    pw        = box_r[47:32] * char_size_r;
    ph        = box_r[63:48] * char_size_r;
    sx        = $signed(curx_r) + (px >>> 4);
    sy        = $signed(cury_r) + (py >>> 4);
    sr        = $signed(left_r) + $signed({4'b0, pw[31:4]});
    sb        = $signed(top_r) + $signed({4'b0, ph[31:4]});
    ksum      = $signed(adv_r[15:0]) + kern_r;
    sadv      = $signed(curx_r) + $signed(m2_r[50:16]);
    khi_field = KIW'(adv_r[35:26]);
    kent      = KIW'(KERNING_ENTRIES);
    kinc      = kidx_r + KIW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    curx_nxt      = curx_r;
    cury_nxt      = cury_r;
    vcount_nxt    = vcount_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    code_nxt      = code_r;
    next_nxt      = next_r;
    has_next_nxt  = has_next_r;
    box_nxt       = box_r;
    uv_nxt        = uv_r;
    adv_nxt       = adv_r;
    left_nxt      = left_r;
    top_nxt       = top_r;
    right_nxt     = right_r;
    bottom_nxt    = bottom_r;
    kidx_nxt      = kidx_r;
    khi_nxt       = khi_r;
    kern_nxt      = kern_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    corner_nxt    = corner_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (it.opcode)
            OP_CURSOR: begin
              if (it.word_select == WSEL_X) begin
                curx_nxt = it.load_value[31:0];
              end else if (it.word_select == WSEL_Y) begin
                cury_nxt = it.load_value[31:0];
              end
            end
            OP_CLEAR: vcount_nxt = '0;
            OP_CHAR: begin
              code_nxt     = it.code;
              next_nxt     = it.next_code;
              has_next_nxt = it.has_next;
              lo_nxt       = '0;
              hi_nxt       = SW'(glyph_n) - SW'(1);
              if (glyph_n != 32'd0) begin
                state_nxt = ST_SRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SRD: state_nxt = ST_SCMP;
      ST_SCMP: begin
        if (g_code_rd == code_r) begin
          if ((32'(vcount_r) + 32'd4) >= 32'(VERTEX_CAPACITY)) begin
            state_nxt = ST_IDLE;
          end else begin
            box_nxt    = g_box_rd;
            uv_nxt     = g_uv_rd;
            adv_nxt    = g_adv_rd;
            vcount_nxt = vcount_r + VCW'(4);
            state_nxt  = ST_CALC1;
          end
        end else begin
          if (code_r < g_code_rd) begin
            hi_nxt = hi_step;
          end else begin
            lo_nxt = lo_step;
          end
          state_nxt = (((code_r < g_code_rd) ? lo_r : lo_step) <=
                       ((code_r < g_code_rd) ? hi_step : hi_r)) ? ST_SRD : ST_IDLE;
        end
      end
      ST_CALC1: begin
        left_nxt  = sat32(sx);
        top_nxt   = sat32(sy);
        state_nxt = ST_CALC2;
      end
      ST_CALC2: begin
        right_nxt  = sat32(sr);
        bottom_nxt = sat32(sb);
        kern_nxt   = '0;
        kidx_nxt   = KIW'(adv_r[25:16]);
        khi_nxt    = (khi_field > kent) ? kent : khi_field;
        state_nxt  = (has_next_r && (KIW'(adv_r[25:16]) <
                      ((khi_field > kent) ? kent : khi_field))) ? ST_KRD : ST_ADV1;
      end
      ST_KRD: state_nxt = ST_KCMP;
      ST_KCMP: begin
        // The first matching entry of the range wins.
        if (k_code_rd == next_r) begin
          kern_nxt  = k_amt_rd;
          state_nxt = ST_ADV1;
        end else begin
          kidx_nxt  = kinc;
          state_nxt = (kinc < khi_r) ? ST_KRD : ST_ADV1;
        end
      end
      ST_ADV1: begin
        m1_nxt    = ksum * $signed({1'b0, char_size_r});
        state_nxt = ST_ADV2;
      end
      ST_ADV2: begin
        m2_nxt    = m1_r * $signed({1'b0, kern_ratio_r});
        state_nxt = ST_ADV3;
      end
      ST_ADV3: begin
        curx_nxt      = sat32(sadv);
        corner_nxt    = CORNER_TL;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (corner_r == CORNER_BL) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      curx_r      <= '0;
      cury_r      <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
      corner_r    <= CORNER_TL;
    end else begin
      state_r     <= state_nxt;
      curx_r      <= curx_nxt;
      cury_r      <= cury_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
      corner_r    <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    code_r     <= code_nxt;
    next_r     <= next_nxt;
    has_next_r <= has_next_nxt;
    box_r      <= box_nxt;
    uv_r       <= uv_nxt;
    adv_r      <= adv_nxt;
    left_r     <= left_nxt;
    top_r      <= top_nxt;
    right_r    <= right_nxt;
    bottom_r   <= bottom_nxt;
    kidx_r     <= kidx_nxt;
    khi_r      <= khi_nxt;
    kern_r     <= kern_nxt;
    m1_r       <= m1_nxt;
    m2_r       <= m2_nxt;
  end

  // Corner payload, selected from the registered quad.
  always_comb begin
    out_ch.valid                = out_valid_r;
    out_ch.payload.bound_u_min  = uv_r[15:0];
    out_ch.payload.bound_v_min  = uv_r[31:16];
    out_ch.payload.bound_u_max  = uv_r[47:32];
    out_ch.payload.bound_v_max  = uv_r[63:48];
    out_ch.payload.vertex_color = text_color_r;
    out_ch.payload.last_corner  = (corner_r == CORNER_BL);
    unique case (corner_r)
      CORNER_TL: begin
        out_ch.payload.vertex_x = left_r;
        out_ch.payload.vertex_y = top_r;
        out_ch.payload.tex_u    = uv_r[15:0];
        out_ch.payload.tex_v    = uv_r[63:48];
      end
      CORNER_TR: begin
        out_ch.payload.vertex_x = right_r;
        out_ch.payload.vertex_y = top_r;
        out_ch.payload.tex_u    = uv_r[47:32];
        out_ch.payload.tex_v    = uv_r[63:48];
      end
      CORNER_BR: begin
        out_ch.payload.vertex_x = right_r;
        out_ch.payload.vertex_y = bottom_r;
        out_ch.payload.tex_u    = uv_r[47:32];
        out_ch.payload.tex_v    = uv_r[31:16];
      end
      default: begin
        out_ch.payload.vertex_x = left_r;
        out_ch.payload.vertex_y = bottom_r;
        out_ch.payload.tex_u    = uv_r[15:0];
        out_ch.payload.tex_v    = uv_r[31:16];
      end
    endcase
  end
endmodule

// File: src/gqtl_checker.sv
// Port-level checks on the layout block's channels, bound to the top level.
module gqtl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // No new item is taken while corners are still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while results pending");

  // The corners of one quad follow each other without a gap.
  a_corner_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("quad corners interrupted");

  // Reset leaves no result offered.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");
endmodule

bind glyph_quad_text_layout gqtl_checker u_gqtl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_last (out_ch.payload.last_corner)
);
